FILE: rtl/tvdi_pkg.sv
// tvdi_pkg: shared types, sizes and the coordinate compare for the vertex indexer
// used by tvdi_match and triangle_vertex_dedup_indexer_top
// no dependencies
`default_nettype none

package tvdi_pkg;

	localparam int VERTEX_CAPACITY = 1024;
	localparam int CORNERS         = 3;

	localparam int IDX_W      = $clog2(VERTEX_CAPACITY);
	localparam int FILL_W     = $clog2(VERTEX_CAPACITY + 1);
	localparam int OUT_IDX_W  = 10;
	localparam int OUT_FILL_W = 11;
	localparam int TALLY_W    = 32;

	// widest of internal and field width, for explicit extend then truncate
	localparam int IDX_XW  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
	localparam int FILL_XW = (FILL_W > OUT_FILL_W) ? FILL_W : OUT_FILL_W;

	localparam logic [62:0]        EXP_ALL_ONES = 63'h7FF0_0000_0000_0000;
	localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;

	typedef struct packed {
		logic [63:0] first_x;
		logic [63:0] first_y;
		logic [63:0] first_z;
		logic [63:0] second_x;
		logic [63:0] second_y;
		logic [63:0] second_z;
		logic [63:0] third_x;
		logic [63:0] third_y;
		logic [63:0] third_z;
		logic [63:0] facet_nx;
		logic [63:0] facet_ny;
		logic [63:0] facet_nz;
	} item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0]  first_index;
		logic [OUT_IDX_W-1:0]  second_index;
		logic [OUT_IDX_W-1:0]  third_index;
		logic [TALLY_W-1:0]    triangle_number;
		logic [63:0]           normal_out_x;
		logic [63:0]           normal_out_y;
		logic [63:0]           normal_out_z;
		logic [OUT_FILL_W-1:0] vertices_in_use;
		logic                  store_full;
	} result_t;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
	} vertex_t;

	// ieee equality on double bit patterns: nan never equal, signed zeros equal
	function automatic logic ieee_eq(input logic [63:0] a, input logic [63:0] b);
		logic nan_a;
		logic nan_b;
		logic zeros;
		nan_a = (a[62:0] > EXP_ALL_ONES);
		nan_b = (b[62:0] > EXP_ALL_ONES);
		zeros = (a[62:0] == '0) && (b[62:0] == '0);
		return !nan_a && !nan_b && (zeros || (a == b));
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tvdi_ram.sv
// tvdi_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module tvdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tvdi_match.sv
// tvdi_match: compares one stored vertex against the three corners of a triangle
// depends on tvdi_pkg
`default_nettype none

module tvdi_match (
	input  wire tvdi_pkg::vertex_t              entry,
	input  wire tvdi_pkg::vertex_t              corner [tvdi_pkg::CORNERS],
	output logic [tvdi_pkg::CORNERS-1:0]        hit
);
	import tvdi_pkg::*;

	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			hit[c] = ieee_eq(entry.x, corner[c].x) &&
				ieee_eq(entry.y, corner[c].y) &&
				ieee_eq(entry.z, corner[c].z);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/triangle_vertex_dedup_indexer_top.sv
// triangle_vertex_dedup_indexer_top: vertex welding index generator, top level
// depends on tvdi_pkg, tvdi_ram, tvdi_match
`default_nettype none

// One triangle word in, one result word out. Each triangle's three corners are
// looked up in a 1024-entry vertex store held in a single ram with a registered
// read: the stored entries are scanned one per cycle with all three corners
// compared in parallel, then the unmatched corners are appended one per cycle.
// One triangle is in work at a time; a finished result sits in the output
// register while the next triangle is taken. The store is not cleared at reset
// and needs no clearing pass: only entries below the fill count are ever read.
module triangle_vertex_dedup_indexer_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire tvdi_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output tvdi_pkg::result_t      result
);
	import tvdi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_APND = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	item_t              item_q;
	logic [FILL_W-1:0]  fill_q;
	logic [IDX_W-1:0]   scan_q;
	logic               issue_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [CORNERS-1:0] found_q;
	logic [IDX_W-1:0]   idx_q [CORNERS];
	logic               full_q;
	logic [1:0]         cnr_q;
	logic [TALLY_W-1:0] tally_q;

	vertex_t            rd_data;
	vertex_t            cur_v;
	vertex_t            corner_v [CORNERS];
	logic [CORNERS-1:0] hit;
	logic               rd_en;
	logic               wr_en;
	logic               accept;
	logic               out_ready;
	logic               space;
	logic [IDX_XW-1:0]  idx_x [CORNERS];
	logic [FILL_XW-1:0] fill_x;

	assign corner_v[0] = '{x: item_q.first_x,  y: item_q.first_y,  z: item_q.first_z};
	assign corner_v[1] = '{x: item_q.second_x, y: item_q.second_y, z: item_q.second_z};
	assign corner_v[2] = '{x: item_q.third_x,  y: item_q.third_y,  z: item_q.third_z};

	always_comb begin
		case (cnr_q)
			2'd1:    cur_v = corner_v[1];
			2'd2:    cur_v = corner_v[2];
			default: cur_v = corner_v[0];
		endcase
	end

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign out_ready  = !result_valid || !result_stall;
	assign space      = (fill_q < FILL_W'(VERTEX_CAPACITY));
	assign rd_en      = (state_q == ST_SCAN) && issue_q;
	assign wr_en      = (state_q == ST_APND) && !found_q[cnr_q] && space;

	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			idx_x[c] = IDX_XW'(idx_q[c]);
		end
		fill_x = FILL_XW'(fill_q);
	end

	tvdi_ram #(
		.WIDTH ($bits(vertex_t)),
		.DEPTH (VERTEX_CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[IDX_W-1:0]),
		.wr_data (cur_v),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	tvdi_match u_match (
		.entry  (rd_data),
		.corner (corner_v),
		.hit    (hit)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			scan_q       <= '0;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			cnr_q        <= '0;
			tally_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (result_valid && !result_stall && state_q != ST_FIN) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (fill_q == '0) ? ST_APND : ST_SCAN;
						issue_q <= (fill_q != '0);
						scan_q  <= '0;
						cnr_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						scan_q <= scan_q + 1'b1;
						if (FILL_W'(scan_q) + FILL_W'(1) == fill_q) begin
							issue_q <= 1'b0;
						end
					end else if (!rd_vld_s1) begin
						state_q <= ST_APND;
					end
				end
				ST_APND: begin
					if (wr_en) begin
						fill_q <= fill_q + 1'b1;
					end
					if (cnr_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						cnr_q <= cnr_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_ready) begin
						result_valid <= 1'b1;
						if (tally_q != TALLY_MAX) begin
							tally_q <= tally_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) begin
			item_q  <= item;
			found_q <= '0;
			full_q  <= 1'b0;
		end
		// ascending scan, so the last matching entry wins
		if (state_q == ST_SCAN && rd_vld_s1) begin
			for (int c = 0; c < CORNERS; c++) begin
				if (hit[c]) begin
					found_q[c] <= 1'b1;
					idx_q[c]   <= rd_idx_s1;
				end
			end
		end
		if (state_q == ST_APND && !found_q[cnr_q]) begin
			if (space) begin
				idx_q[cnr_q] <= fill_q[IDX_W-1:0];
			end else begin
				idx_q[cnr_q] <= '0;
				full_q       <= 1'b1;
			end
		end
		if (state_q == ST_FIN && out_ready) begin
			result.first_index     <= idx_x[0][OUT_IDX_W-1:0];
			result.second_index    <= idx_x[1][OUT_IDX_W-1:0];
			result.third_index     <= idx_x[2][OUT_IDX_W-1:0];
			result.triangle_number <= tally_q;
			result.normal_out_x    <= item_q.facet_nx;
			result.normal_out_y    <= item_q.facet_ny;
			result.normal_out_z    <= item_q.facet_nz;
			result.vertices_in_use <= fill_x[OUT_FILL_W-1:0];
			result.store_full      <= full_q;
		end
	end

endmodule

`default_nettype wire

FILE: tb/triangle_weld_checker.sv
`timescale 1ns / 100ps
// triangle_weld_checker: watches the triangle and result channels of the vertex indexer,
// predicts every result word from its own copy of the vertex store and compares it
// depends on tvdi_pkg
module triangle_weld_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire tvdi_pkg::item_t   item,
	input  wire logic              result_valid,
	input  wire logic              result_stall,
	input  wire tvdi_pkg::result_t result,
	output int                     mismatches,
	output int                     outstanding
);
	import tvdi_pkg::*;

	vertex_t            welded [VERTEX_CAPACITY];
	int                 welded_count;
	logic [TALLY_W-1:0] tally;
	result_t            pending_results [$];

	function automatic logic coord_nan(input logic [63:0] v);
		return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
	endfunction

	function automatic logic coord_same(input logic [63:0] a, input logic [63:0] b);
		if (coord_nan(a) || coord_nan(b))
			return 1'b0;
		return ((a[62:0] == '0) && (b[62:0] == '0)) || (a == b);
	endfunction

	function automatic logic vertex_same(input vertex_t a, input vertex_t b);
		return coord_same(a.x, b.x) && coord_same(a.y, b.y) && coord_same(a.z, b.z);
	endfunction

	// all corners searched first, last hit wins, then misses appended in corner order
	function automatic result_t weld_triangle(input item_t t);
		vertex_t              corner [CORNERS];
		logic                 hit [CORNERS];
		logic [OUT_IDX_W-1:0] slot [CORNERS];
		logic                 overflow;
		result_t              r;
		int                   e;
		int                   k;
		corner[0] = {t.first_x, t.first_y, t.first_z};
		corner[1] = {t.second_x, t.second_y, t.second_z};
		corner[2] = {t.third_x, t.third_y, t.third_z};
		overflow = 1'b0;
		for (k = 0; k < CORNERS; k++) begin
			hit[k] = 1'b0;
			slot[k] = '0;
		end
		for (e = 0; e < welded_count; e++) begin
			for (k = 0; k < CORNERS; k++) begin
				if (vertex_same(welded[e], corner[k])) begin
					hit[k] = 1'b1;
					slot[k] = e[OUT_IDX_W-1:0];
				end
			end
		end
		for (k = 0; k < CORNERS; k++) begin
			if (!hit[k]) begin
				if (welded_count < VERTEX_CAPACITY) begin
					welded[welded_count] = corner[k];
					slot[k] = welded_count[OUT_IDX_W-1:0];
					welded_count++;
				end else begin
					slot[k] = '0;
					overflow = 1'b1;
				end
			end
		end
		r.first_index     = slot[0];
		r.second_index    = slot[1];
		r.third_index     = slot[2];
		r.triangle_number = tally;
		r.normal_out_x    = t.facet_nx;
		r.normal_out_y    = t.facet_ny;
		r.normal_out_z    = t.facet_nz;
		r.vertices_in_use = welded_count[OUT_FILL_W-1:0];
		r.store_full      = overflow;
		if (tally != TALLY_MAX)
			tally++;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", field, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
		welded_count = 0;
		tally = '0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall)
				pending_results.push_back(weld_triangle(item));
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("first_index", want.first_index, result.first_index);
					check_field("second_index", want.second_index, result.second_index);
					check_field("third_index", want.third_index, result.third_index);
					check_field("triangle_number", want.triangle_number,
						result.triangle_number);
					check_field("normal_out_x", want.normal_out_x, result.normal_out_x);
					check_field("normal_out_y", want.normal_out_y, result.normal_out_y);
					check_field("normal_out_z", want.normal_out_z, result.normal_out_z);
					check_field("vertices_in_use", want.vertices_in_use,
						result.vertices_in_use);
					check_field("store_full", want.store_full, result.store_full);
				end
			end
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: tb/tb_triangle_vertex_dedup_indexer_top.sv
`timescale 1ns / 100ps
// tb_triangle_vertex_dedup_indexer_top: drives triangle words into the vertex indexer
// under several idling patterns and gives the verdict from triangle_weld_checker
// depends on tvdi_pkg, triangle_vertex_dedup_indexer_top, triangle_weld_checker
module tb_triangle_vertex_dedup_indexer_top;
	import tvdi_pkg::*;

	localparam int HOLD_CYCLES      = 3000;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int DRAIN_CYCLES     = 1100;
	localparam int RANDOM_PER_PHASE = 143;
	localparam int ONE_SIDE_PCT     = 74;
	localparam int BOTH_SIDES_PCT   = 24;

	localparam logic [63:0] POS_ZERO    = 64'h0000_0000_0000_0000;
	localparam logic [63:0] NEG_ZERO    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] QNAN        = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] SNAN        = 64'h7FF0_0000_0000_0001;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX_FIN     = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_SUB     = 64'h0000_0000_0000_0001;
	localparam logic [63:0] NEG_MIN_SUB = 64'h8000_0000_0000_0001;
	localparam logic [63:0] ONE         = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] NEG_ONE     = 64'hBFF0_0000_0000_0000;
	localparam logic [63:0] ALT         = 64'h5555_5555_5555_5555;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	idle_mode_e idle_mode;
	logic       hold_request;
	int         mismatches;
	int         outstanding;
	int         quiet_cycles;
	vertex_t    seen_corners [$];

	triangle_vertex_dedup_indexer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	triangle_weld_checker weld_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver side, with one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			result_stall = ((idle_mode == IDLE_RECEIVER) &&
				($urandom_range(0, 99) < ONE_SIDE_PCT)) ||
				((idle_mode == IDLE_BOTH) && ($urandom_range(0, 99) < BOTH_SIDES_PCT));
		end
	end

	function automatic logic [63:0] fresh_coord();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			6: v = {v[63], 63'h0};
			7: v = {v[63], POS_INF[62:0]};
			8: v = {v[63], 11'h7FF, (v[51:0] == '0) ? 52'h1 : v[51:0]};
			9: v = {v[63], 11'h3FF + {9'h0, v[53:52]}, 52'h0};
			default: ;
		endcase
		return v;
	endfunction

	function automatic vertex_t pick_corner(input vertex_t earlier [CORNERS], input int k);
		vertex_t v;
		int      roll;
		roll = $urandom_range(0, 99);
		if (roll < 20 && seen_corners.size() != 0)
			v = seen_corners[$urandom_range(0, seen_corners.size() - 1)];
		else if (roll < 26 && k > 0)
			v = earlier[$urandom_range(0, k - 1)];
		else
			v = {fresh_coord(), fresh_coord(), fresh_coord()};
		// zeros of either sign must still weld
		if (v.x[62:0] == '0 && $urandom_range(0, 1))
			v.x[63] = ~v.x[63];
		if (v.y[62:0] == '0 && $urandom_range(0, 1))
			v.y[63] = ~v.y[63];
		if (v.z[62:0] == '0 && $urandom_range(0, 1))
			v.z[63] = ~v.z[63];
		return v;
	endfunction

	task automatic offer(input vertex_t a, input vertex_t b, input vertex_t c,
		input logic [63:0] nx, input logic [63:0] ny, input logic [63:0] nz);
		@(negedge clk);
		while (((idle_mode == IDLE_SENDER) && ($urandom_range(0, 99) < ONE_SIDE_PCT)) ||
			((idle_mode == IDLE_BOTH) && ($urandom_range(0, 99) < BOTH_SIDES_PCT))) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item = {a, b, c, nx, ny, nz};
		item_valid = 1'b1;
		seen_corners.push_back(a);
		seen_corners.push_back(b);
		seen_corners.push_back(c);
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic random_triangle();
		vertex_t corner [CORNERS];
		int      k;
		for (k = 0; k < CORNERS; k++)
			corner[k] = pick_corner(corner, k);
		offer(corner[0], corner[1], corner[2], fresh_coord(), fresh_coord(), fresh_coord());
	endtask

	task automatic run_phase(input idle_mode_e mode);
		idle_mode = mode;
		repeat (RANDOM_PER_PHASE)
			random_triangle();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		idle_mode = IDLE_NONE;
		hold_request = 1'b0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// equal new corners in one triangle get separate entries
		offer({POS_ZERO, POS_ZERO, POS_ZERO}, {POS_ZERO, POS_ZERO, POS_ZERO},
			{POS_ZERO, POS_ZERO, POS_ZERO}, '0, '0, '0);
		// signed zeros match, last entry wins
		offer({NEG_ZERO, NEG_ZERO, NEG_ZERO}, {NEG_ZERO, POS_ZERO, NEG_ZERO},
			{POS_ZERO, NEG_ZERO, POS_ZERO}, ALL_ONES, ALL_ONES, ALL_ONES);
		// nan never matches
		offer({QNAN, POS_ZERO, POS_ZERO}, {QNAN, POS_ZERO, POS_ZERO},
			{POS_ZERO, POS_ZERO, POS_ZERO}, ALT, ~ALT, '0);
		offer({ONE, ONE, ONE}, {ONE, ONE, ONE}, {POS_INF, NEG_INF, POS_INF},
			~ALT, ALT, ALL_ONES);
		offer({POS_INF, NEG_INF, POS_INF}, {ALL_ONES, ALL_ONES, ALL_ONES},
			{MAX_FIN, MIN_SUB, NEG_MIN_SUB}, MAX_FIN, NEG_INF, QNAN);
		offer({MAX_FIN, MIN_SUB, NEG_MIN_SUB}, {ONE, ONE, ONE},
			{NEG_ZERO, POS_ZERO, POS_ZERO}, NEG_ZERO, MIN_SUB, SNAN);
		offer({SNAN, ONE, ONE}, {ONE, SNAN, ONE}, {ONE, ONE, SNAN}, ONE, NEG_ONE, ALT);
		offer({NEG_MIN_SUB, MIN_SUB, MAX_FIN}, {ONE, ONE, NEG_ONE}, {ONE, ONE, ONE},
			POS_INF, ALL_ONES, '0);
		offer({ALL_ONES, ALL_ONES, ALL_ONES}, {MIN_SUB, MIN_SUB, MIN_SUB},
			{ONE, ONE, NEG_ONE}, '0, ALT, ALL_ONES);

		// long receiver hold while words keep coming
		hold_request = 1'b1;
		run_phase(IDLE_NONE);
		run_phase(IDLE_SENDER);
		run_phase(IDLE_RECEIVER);
		run_phase(IDLE_BOTH);

		@(negedge clk);
		item_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
